@@ rtl/clipped_pixel_raster_writer_unit_macros.svh @@
// Assertion macros for the clipped pixel raster writer.
// Taken in by the top level with `include; no other dependencies.
`ifndef CLIPPED_PIXEL_RASTER_WRITER_UNIT_MACROS_SVH
`define CLIPPED_PIXEL_RASTER_WRITER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPRW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cprw assertion failed");

// Next-cycle implication, checked outside reset.
`define CPRW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cprw assertion failed");

`endif

@@ rtl/cprw_pkg.sv @@
// Shared types, codes and constants of the clipped pixel raster writer.
// No dependencies; used by the interfaces, the register file and the top level.
package cprw_pkg;

	localparam int unsigned COORD_BITS_DEF = 12;
	localparam int unsigned SCREEN_BITS    = 12;
	localparam int unsigned SPAN_BITS      = 11;
	localparam int unsigned STRIDE_BITS    = 16;
	localparam int unsigned CFG_IDX_BITS   = 3;

	typedef enum logic [1:0] {
		ACT_BEGIN_FILL  = 2'd0,
		ACT_BEGIN_GLYPH = 2'd1,
		ACT_STEP        = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		FMT_8    = 2'd0,
		FMT_565  = 2'd1,
		FMT_32   = 2'd2,
		FMT_NONE = 2'd3
	} fmt_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FRAME_BASE    = 3'd0,
		REG_PIXEL_FORMAT  = 3'd1,
		REG_LINE_STRIDE   = 3'd2,
		REG_SCREEN_WIDTH  = 3'd3,
		REG_SCREEN_HEIGHT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [31:0]            frame_base;
		fmt_t                   pixel_format;
		logic [STRIDE_BITS-1:0] line_stride;
		logic [SCREEN_BITS-1:0] screen_width;
		logic [SCREEN_BITS-1:0] screen_height;
	} cfg_t;

	localparam logic [31:0]            FRAME_BASE_RST    = 32'd0;
	localparam fmt_t                   PIXEL_FORMAT_RST  = FMT_32;
	localparam logic [STRIDE_BITS-1:0] LINE_STRIDE_RST   = 16'd2560;
	localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 12'd640;
	localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 12'd480;

	// 0x00RRGGBB to RGB565 in the low half word.
	function automatic logic [31:0] pack_565(input logic [31:0] c);
		return {16'd0, c[23:19], c[15:10], c[7:3]};
	endfunction

endpackage

@@ rtl/cprw_ifs.sv @@
// Handshake channels of the clipped pixel raster writer: input items,
// write results and configuration writes. Depends on cprw_pkg.
interface cprw_in_if #(
	parameter int unsigned COORD_BITS = cprw_pkg::COORD_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic [1:0]                      action;
	logic signed [COORD_BITS-1:0]    corner_x;
	logic signed [COORD_BITS-1:0]    corner_y;
	logic [cprw_pkg::SPAN_BITS-1:0]  region_width;
	logic [cprw_pkg::SPAN_BITS-1:0]  region_height;
	logic [31:0]                     draw_color;
	logic [7:0]                      mask_value;

	modport source (
		output valid, action, corner_x, corner_y, region_width, region_height,
			draw_color, mask_value,
		input  ready
	);
	modport sink (
		input  valid, action, corner_x, corner_y, region_width, region_height,
			draw_color, mask_value,
		output ready
	);
endinterface

interface cprw_out_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [31:0] write_address;
	logic [31:0] write_data;
	logic [1:0]  write_size;
	logic        region_done;
	logic        format_error;

	modport source (
		output valid, write_enable, write_address, write_data, write_size,
			region_done, format_error,
		input  ready
	);
	modport sink (
		input  valid, write_enable, write_address, write_data, write_size,
			region_done, format_error,
		output ready
	);
endinterface

interface cprw_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cprw_pkg::CFG_IDX_BITS-1:0] index;
	logic [31:0]                       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/clipped_pixel_raster_writer_unit.sv @@
// Clipped pixel raster writer: takes one item per cycle, every cycle the write
// port is free. A begin item opens a region and gives no result; each pixel
// step of an open region gives one result, which goes from the walk position
// register through clip, address and color into the result register, which
// drives the write port. The row offset multiply (row times line stride)
// sets the path.
// Ready drops only while both stages hold items and the result is not taken.
// Depends on cprw_pkg, cprw_ifs, cprw_cfg_regs and the assertion macro header.
`include "clipped_pixel_raster_writer_unit_macros.svh"

module clipped_pixel_raster_writer_unit #(
	parameter int unsigned COORD_BITS = cprw_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cprw_cfg_if.sink    cfg,
	cprw_in_if.sink     pix_in,
	cprw_out_if.source  wr_out
);

	localparam int unsigned SPAN_BITS = cprw_pkg::SPAN_BITS;
	localparam int unsigned SCR_BITS  = cprw_pkg::SCREEN_BITS;
	// wide enough for the most negative origin and the largest origin plus offset
	localparam int unsigned XW        = ((COORD_BITS > SCR_BITS) ? COORD_BITS : SCR_BITS) + 1;
	localparam int unsigned PROD_BITS = SCR_BITS + cprw_pkg::STRIDE_BITS;

	cprw_pkg::cfg_t regs;

	cprw_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// region state
	logic signed [COORD_BITS-1:0] left_col_q;
	logic signed [COORD_BITS-1:0] top_row_q;
	logic [SPAN_BITS-1:0]         span_width_q;
	logic [SPAN_BITS-1:0]         span_height_q;
	logic [SPAN_BITS-1:0]         col_offset_q;
	logic [SPAN_BITS-1:0]         row_offset_q;
	logic [31:0]                  pen_color_q;
	logic                         glyph_mode_q;
	logic                         walk_active_q;

	// stage 1: walk position
	logic                valid_s1;
	logic signed [XW-1:0] x_s1;
	logic signed [XW-1:0] y_s1;
	logic                paint_s1;
	logic                done_s1;
	logic [31:0]         color_s1;

	// stage 2: result register
	logic        valid_s2;
	logic        we_s2;
	logic [31:0] addr_s2;
	logic [31:0] data_s2;
	logic [1:0]  size_s2;
	logic        done_s2;
	logic        ferr_s2;

	cprw_pkg::act_t       act;
	logic                 s1_adv;
	logic                 in_ready;
	logic                 in_fire;
	logic                 step_fire;
	logic                 step_done;
	logic                 col_wrap;
	logic [SPAN_BITS:0]   col_inc;
	logic [SPAN_BITS:0]   row_inc;
	logic signed [XW-1:0] step_x;
	logic signed [XW-1:0] step_y;

	assign act       = cprw_pkg::act_t'(pix_in.action);
	assign s1_adv    = !valid_s2 || wr_out.ready;
	assign in_ready  = !valid_s1 || s1_adv;
	assign in_fire   = pix_in.valid && in_ready;
	assign step_fire = in_fire && (act == cprw_pkg::ACT_STEP) && walk_active_q;

	assign col_inc   = (SPAN_BITS+1)'(col_offset_q) + 1'b1;
	assign row_inc   = (SPAN_BITS+1)'(row_offset_q) + 1'b1;
	assign col_wrap  = col_inc >= (SPAN_BITS+1)'(span_width_q);
	assign step_done = (col_inc == (SPAN_BITS+1)'(span_width_q)) &&
		(row_inc == (SPAN_BITS+1)'(span_height_q));

	assign step_x = XW'(left_col_q) + $signed(XW'(col_offset_q));
	assign step_y = XW'(top_row_q) + $signed(XW'(row_offset_q));

	assign pix_in.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_col_q    <= '0;
			top_row_q     <= '0;
			span_width_q  <= '0;
			span_height_q <= '0;
			col_offset_q  <= '0;
			row_offset_q  <= '0;
			pen_color_q   <= '0;
			glyph_mode_q  <= 1'b0;
			walk_active_q <= 1'b0;
		end else if (in_fire) begin
			unique case (act)
				cprw_pkg::ACT_BEGIN_FILL, cprw_pkg::ACT_BEGIN_GLYPH: begin
					// a new begin abandons any open region
					left_col_q    <= pix_in.corner_x;
					top_row_q     <= pix_in.corner_y;
					span_width_q  <= pix_in.region_width;
					span_height_q <= pix_in.region_height;
					pen_color_q   <= pix_in.draw_color;
					glyph_mode_q  <= (act == cprw_pkg::ACT_BEGIN_GLYPH);
					col_offset_q  <= '0;
					row_offset_q  <= '0;
					walk_active_q <= (pix_in.region_width != '0) &&
						(pix_in.region_height != '0);
				end
				cprw_pkg::ACT_STEP: begin
					if (walk_active_q) begin
						if (col_wrap) begin
							col_offset_q <= '0;
							row_offset_q <= row_inc[SPAN_BITS-1:0];
						end else begin
							col_offset_q <= col_inc[SPAN_BITS-1:0];
						end
						if (step_done) begin
							walk_active_q <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= step_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			x_s1     <= step_x;
			y_s1     <= step_y;
			paint_s1 <= !glyph_mode_q || (pix_in.mask_value != '0);
			done_s1  <= step_done;
			color_s1 <= pen_color_q;
		end
	end

	// clip, address and color
	logic                on_screen;
	logic                draw;
	logic [SCR_BITS-1:0] x_scr;
	logic [SCR_BITS-1:0] y_scr;
	logic [PROD_BITS-1:0] row_bytes;
	logic [31:0]         col_bytes;
	logic                we_d;
	logic [31:0]         addr_d;
	logic [31:0]         data_d;
	logic [1:0]          size_d;
	logic                ferr_d;

	assign on_screen = !x_s1[XW-1] && !y_s1[XW-1] &&
		(x_s1[XW-2:0] < (XW-1)'(regs.screen_width)) &&
		(y_s1[XW-2:0] < (XW-1)'(regs.screen_height));
	assign draw      = on_screen && paint_s1;
	// a drawn location lies below the screen size, so the low bits carry it
	assign x_scr     = x_s1[SCR_BITS-1:0];
	assign y_scr     = y_s1[SCR_BITS-1:0];
	assign row_bytes = PROD_BITS'(y_scr) * PROD_BITS'(regs.line_stride);

	always_comb begin
		we_d      = 1'b0;
		addr_d    = '0;
		data_d    = '0;
		size_d    = '0;
		ferr_d    = 1'b0;
		col_bytes = 32'(x_scr);
		unique case (regs.pixel_format)
			cprw_pkg::FMT_8: begin
				col_bytes = 32'(x_scr);
				data_d    = {24'd0, color_s1[7:0]};
			end
			cprw_pkg::FMT_565: begin
				col_bytes = 32'(x_scr) << 1;
				data_d    = cprw_pkg::pack_565(color_s1);
			end
			cprw_pkg::FMT_32: begin
				col_bytes = 32'(x_scr) << 2;
				data_d    = color_s1;
			end
			cprw_pkg::FMT_NONE: begin
				ferr_d = draw;
			end
		endcase
		if (draw && (regs.pixel_format != cprw_pkg::FMT_NONE)) begin
			we_d   = 1'b1;
			size_d = regs.pixel_format;
			addr_d = regs.frame_base + col_bytes + 32'(row_bytes);
		end else begin
			data_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			we_s2   <= we_d;
			addr_s2 <= addr_d;
			data_s2 <= data_d;
			size_s2 <= size_d;
			done_s2 <= done_s1;
			ferr_s2 <= ferr_d;
		end
	end

	assign wr_out.valid         = valid_s2;
	assign wr_out.write_enable  = we_s2;
	assign wr_out.write_address = addr_s2;
	assign wr_out.write_data    = data_s2;
	assign wr_out.write_size    = size_s2;
	assign wr_out.region_done   = done_s2;
	assign wr_out.format_error  = ferr_s2;

	`CPRW_ASSERT_IMP(a_we_no_ferr, clk, arst_n, valid_s2, !(we_s2 && ferr_s2))
	`CPRW_ASSERT_IMP(a_size_legal, clk, arst_n, valid_s2 && we_s2, size_s2 != 2'(cprw_pkg::FMT_NONE))
	`CPRW_ASSERT_NXT(a_done_closes, clk, arst_n, step_fire && step_done, !walk_active_q)
	`CPRW_ASSERT_IMP(a_walk_nonempty, clk, arst_n, walk_active_q, (|span_width_q) && (|span_height_q))

endmodule

@@ rtl/cprw_cfg_regs.sv @@
// Configuration register file of the clipped pixel raster writer.
// Depends on cprw_pkg and cprw_cfg_if; writes to unknown indexes are dropped.
module cprw_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	cprw_cfg_if.sink         cfg,
	output cprw_pkg::cfg_t   regs
);

	cprw_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.frame_base    <= cprw_pkg::FRAME_BASE_RST;
			regs_q.pixel_format  <= cprw_pkg::PIXEL_FORMAT_RST;
			regs_q.line_stride   <= cprw_pkg::LINE_STRIDE_RST;
			regs_q.screen_width  <= cprw_pkg::SCREEN_WIDTH_RST;
			regs_q.screen_height <= cprw_pkg::SCREEN_HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cprw_pkg::reg_idx_t'(cfg.index))
				cprw_pkg::REG_FRAME_BASE: begin
					regs_q.frame_base <= cfg.data;
				end
				cprw_pkg::REG_PIXEL_FORMAT: begin
					regs_q.pixel_format <= cprw_pkg::fmt_t'(cfg.data[1:0]);
				end
				cprw_pkg::REG_LINE_STRIDE: begin
					regs_q.line_stride <= cfg.data[cprw_pkg::STRIDE_BITS-1:0];
				end
				cprw_pkg::REG_SCREEN_WIDTH: begin
					regs_q.screen_width <= cfg.data[cprw_pkg::SCREEN_BITS-1:0];
				end
				cprw_pkg::REG_SCREEN_HEIGHT: begin
					regs_q.screen_height <= cfg.data[cprw_pkg::SCREEN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
